### rtl/core/dq_pkg.sv
// ----------------------------------------------------------------------------
// dq_pkg
// Word types and command/result codes shared by the bounded deque block.
// ----------------------------------------------------------------------------
package dq_pkg;

  localparam int unsigned CMD_W  = 4;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned RUN_W  = 7;
  localparam int unsigned KIND_W = 2;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 4'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 4'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 4'd2;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 4'd3;
  localparam logic [CMD_W-1:0] CMD_DELETE     = 4'd4;
  localparam logic [CMD_W-1:0] CMD_CLEAR      = 4'd5;
  localparam logic [CMD_W-1:0] CMD_FIRST_N    = 4'd6;
  localparam logic [CMD_W-1:0] CMD_LAST_N     = 4'd7;
  localparam logic [CMD_W-1:0] CMD_ALL        = 4'd8;

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_DONE     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REJECTED = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ENTRY    = 2'd2;
  localparam logic [KIND_W-1:0] KIND_EMPTY    = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]         cmd;
    logic signed [DATA_W-1:0] item_value;
    logic [RUN_W-1:0]         run_count;
  } in_word_t;

  typedef struct packed {
    logic [KIND_W-1:0]        result_kind;
    logic signed [DATA_W-1:0] entry_value;
    logic                     last;
  } out_word_t;

endpackage

### rtl/core/dq_ram.sv
// ----------------------------------------------------------------------------
// dq_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module dq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read data holds its value until the next read is issued.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/core/dq_outq.sv
// ----------------------------------------------------------------------------
// dq_outq
// Two-word result queue that decouples the sequencer from the output channel.
// ----------------------------------------------------------------------------
module dq_outq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  dq_pkg::out_word_t push_word,
  output logic              full,
  output logic              out_valid,
  input  logic              out_ready,
  output dq_pkg::out_word_t out_data
);

  dq_pkg::out_word_t word0_r, word0_nxt;
  dq_pkg::out_word_t word1_r, word1_nxt;
  logic [1:0]        cnt_r, cnt_nxt;
  logic              pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = word0_r;
  assign full      = (cnt_r == 2'd2);

  always_comb begin
    word0_nxt = word0_r;
    word1_nxt = word1_r;
    cnt_nxt   = cnt_r;
    if (pop && push) begin
      if (cnt_r == 2'd1) begin
        word0_nxt = push_word;
      end else begin
        word0_nxt = word1_r;
        word1_nxt = push_word;
      end
    end else if (pop) begin
      word0_nxt = word1_r;
      cnt_nxt   = cnt_r - 2'd1;
    end else if (push) begin
      if (cnt_r == 2'd0) begin
        word0_nxt = push_word;
      end else begin
        word1_nxt = push_word;
      end
      cnt_nxt = cnt_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    word0_r <= word0_nxt;
    word1_r <= word1_nxt;
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

### rtl/core/bounded_deque_with_value_delete.sv
// ----------------------------------------------------------------------------
// bounded_deque_with_value_delete
// Bounded double-ended queue of words in a ring memory, with delete by value.
// ----------------------------------------------------------------------------
// Each accepted word carries one command. Push, pop, clear and unused codes
// are accepted, then executed, before the next word is taken; execution
// waits while the result queue is full. The emit commands and delete by
// value then walk the ring through the single read port of the entry
// memory, one entry a cycle (emit only while the result queue has room),
// and delete writes survivors back through the write port behind the read. A
// two-word result queue lets the next command start while results wait to be
// taken. Entries are never cleared in the memory; only held entries are read.
module bounded_deque_with_value_delete #(
  parameter int unsigned CAPACITY    = 64,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  dq_pkg::in_word_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output dq_pkg::out_word_t out_data
);

  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_EMIT,
    ST_DEL,
    ST_DONE
  } state_t;

  state_t                    state_r, state_nxt;
  logic [dq_pkg::CMD_W-1:0]  cmd_r, cmd_nxt;
  logic [VALUE_WIDTH-1:0]    val_r, val_nxt;
  logic [dq_pkg::RUN_W-1:0]  n_r, n_nxt;
  logic [IW-1:0]             front_r, front_nxt;
  logic [CW-1:0]             count_r, count_nxt;
  logic [IW-1:0]             rd_slot_r, rd_slot_nxt;
  logic [IW-1:0]             wr_slot_r, wr_slot_nxt;
  logic [CW-1:0]             left_r, left_nxt;
  logic [CW-1:0]             kept_r, kept_nxt;

  logic                      ram_we;
  logic [IW-1:0]             ram_waddr;
  logic [VALUE_WIDTH-1:0]    ram_wdata;
  logic                      ram_re;
  logic [IW-1:0]             ram_raddr;
  logic [VALUE_WIDTH-1:0]    ram_rdata;

  logic                      q_push;
  logic                      q_full;
  dq_pkg::out_word_t         q_word;

  logic [63:0]               in_val64;
  logic [63:0]               rd_val64;
  logic                      full;
  logic [dq_pkg::RUN_W-1:0]  count_ext;
  logic [CW-1:0]             k;
  logic [CW-1:0]             tail_off;
  logic [IW-1:0]             front_dec;
  logic [IW-1:0]             start_slot;

  function automatic logic [IW-1:0] ring_inc(input logic [IW-1:0] x);
    logic [IW-1:0] r;
    r = (x == IW'(CAPACITY - 1)) ? '0 : x + IW'(1);
    return r;
  endfunction

  function automatic logic [IW-1:0] slot_of(input logic [IW-1:0] base,
                                            input logic [IW-1:0] off);
    logic [IW:0] s;
    s = {1'b0, base} + {1'b0, off};
    if (s >= (IW + 1)'(CAPACITY)) begin
      s = s - (IW + 1)'(CAPACITY);
    end
    return s[IW-1:0];
  endfunction

  assign in_ready  = (state_r == ST_IDLE);
  assign in_val64  = {32'b0, in_data.item_value};
  assign rd_val64  = 64'(ram_rdata);
  assign full      = (count_r == CW'(CAPACITY));
  assign count_ext = dq_pkg::RUN_W'(count_r);
  assign k         = (n_r < count_ext) ? n_r[CW-1:0] : count_r;
  assign tail_off  = count_r - k;
  assign front_dec = (front_r == '0) ? IW'(CAPACITY - 1) : front_r - IW'(1);
  assign start_slot = slot_of(front_r, tail_off[IW-1:0]);

  always_comb begin
    state_nxt   = state_r;
    cmd_nxt     = cmd_r;
    val_nxt     = val_r;
    n_nxt       = n_r;
    front_nxt   = front_r;
    count_nxt   = count_r;
    rd_slot_nxt = rd_slot_r;
    wr_slot_nxt = wr_slot_r;
    left_nxt    = left_r;
    kept_nxt    = kept_r;
    ram_we      = 1'b0;
    ram_waddr   = front_r;
    ram_wdata   = val_r;
    ram_re      = 1'b0;
    ram_raddr   = front_r;
    q_push      = 1'b0;
    q_word      = '{result_kind: dq_pkg::KIND_DONE, entry_value: '0, last: 1'b1};

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd_nxt   = in_data.cmd;
          val_nxt   = in_val64[VALUE_WIDTH-1:0];
          n_nxt     = in_data.run_count;
          state_nxt = ST_EXEC;
        end
      end

      ST_EXEC: begin
        if (!q_full) begin
          q_push    = 1'b1;
          state_nxt = ST_IDLE;
          case (cmd_r)
            dq_pkg::CMD_PUSH_FRONT: begin
              if (full) begin
                q_word.result_kind = dq_pkg::KIND_REJECTED;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = front_dec;
                front_nxt = front_dec;
                count_nxt = count_r + CW'(1);
              end
            end
            dq_pkg::CMD_PUSH_BACK: begin
              if (full) begin
                q_word.result_kind = dq_pkg::KIND_REJECTED;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = slot_of(front_r, count_r[IW-1:0]);
                count_nxt = count_r + CW'(1);
              end
            end
            dq_pkg::CMD_POP_FRONT: begin
              if (count_r != '0) begin
                front_nxt = ring_inc(front_r);
                count_nxt = count_r - CW'(1);
              end
            end
            dq_pkg::CMD_POP_BACK: begin
              if (count_r != '0) begin
                count_nxt = count_r - CW'(1);
              end
            end
            dq_pkg::CMD_DELETE: begin
              if (count_r != '0) begin
                q_push      = 1'b0;
                ram_re      = 1'b1;
                ram_raddr   = front_r;
                rd_slot_nxt = ring_inc(front_r);
                wr_slot_nxt = front_r;
                left_nxt    = count_r;
                kept_nxt    = '0;
                state_nxt   = ST_DEL;
              end
            end
            dq_pkg::CMD_CLEAR: begin
              count_nxt = '0;
              front_nxt = '0;
            end
            dq_pkg::CMD_FIRST_N: begin
              if (k == '0) begin
                q_word.result_kind = dq_pkg::KIND_EMPTY;
              end else begin
                q_push      = 1'b0;
                ram_re      = 1'b1;
                ram_raddr   = front_r;
                rd_slot_nxt = ring_inc(front_r);
                left_nxt    = k;
                state_nxt   = ST_EMIT;
              end
            end
            dq_pkg::CMD_LAST_N: begin
              if (count_r == '0) begin
                q_word.result_kind = dq_pkg::KIND_DONE;
              end else if (k == '0) begin
                q_word.result_kind = dq_pkg::KIND_EMPTY;
              end else begin
                q_push      = 1'b0;
                ram_re      = 1'b1;
                ram_raddr   = start_slot;
                rd_slot_nxt = ring_inc(start_slot);
                left_nxt    = k;
                state_nxt   = ST_EMIT;
              end
            end
            dq_pkg::CMD_ALL: begin
              if (count_r != '0) begin
                q_push      = 1'b0;
                ram_re      = 1'b1;
                ram_raddr   = front_r;
                rd_slot_nxt = ring_inc(front_r);
                left_nxt    = count_r;
                state_nxt   = ST_EMIT;
              end
            end
            default: begin
              q_word.result_kind = dq_pkg::KIND_DONE;
            end
          endcase
        end
      end

      // The read data for the current entry is always present here; it holds
      // while the result queue is full because no new read is issued.
      ST_EMIT: begin
        if (!q_full) begin
          q_push             = 1'b1;
          q_word.result_kind = dq_pkg::KIND_ENTRY;
          q_word.entry_value = rd_val64[dq_pkg::DATA_W-1:0];
          q_word.last        = (left_r == CW'(1));
          if (left_r != CW'(1)) begin
            ram_re      = 1'b1;
            ram_raddr   = rd_slot_r;
            rd_slot_nxt = ring_inc(rd_slot_r);
            left_nxt    = left_r - CW'(1);
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end

      // Survivors are written back at the compacted position, which never
      // runs ahead of the read position, so no read sees a fresh write.
      ST_DEL: begin
        if (ram_rdata != val_r) begin
          ram_we      = 1'b1;
          ram_waddr   = wr_slot_r;
          ram_wdata   = ram_rdata;
          wr_slot_nxt = ring_inc(wr_slot_r);
          kept_nxt    = kept_r + CW'(1);
        end
        if (left_r != CW'(1)) begin
          ram_re      = 1'b1;
          ram_raddr   = rd_slot_r;
          rd_slot_nxt = ring_inc(rd_slot_r);
          left_nxt    = left_r - CW'(1);
        end else begin
          count_nxt = kept_nxt;
          state_nxt = ST_DONE;
        end
      end

      ST_DONE: begin
        if (!q_full) begin
          q_push    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    val_r     <= val_nxt;
    n_r       <= n_nxt;
    rd_slot_r <= rd_slot_nxt;
    wr_slot_r <= wr_slot_nxt;
    left_r    <= left_nxt;
    kept_r    <= kept_nxt;
    if (!rst_n) begin
      state_r <= ST_IDLE;
      front_r <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      front_r <= front_nxt;
      count_r <= count_nxt;
    end
  end

  dq_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  dq_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_word (q_word),
    .full      (q_full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // The number held never exceeds the ring size.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // The front pointer always names a slot of the ring.
  a_front_bound: assert property (@(posedge clk) disable iff (!rst_n)
    front_r <= IW'(CAPACITY - 1))
    else $error("front pointer outside the ring");

  // The sequencer never offers a result to a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("result pushed into a full queue");

  // Compaction can only shrink the store.
  a_delete_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DEL) |=> (count_r <= $past(count_r)))
    else $error("delete grew the entry count");

  // A survivor write never lands on the slot being read in the same cycle.
  a_no_collision: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DEL && ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("compaction write collides with read");

endmodule
